// File: sv/comment_and_whitespace_stripper_unit_assert.svh
// Assertion macros shared by the comment and whitespace stripper RTL.
// Each macro expects clk and rst_n in the enclosing module scope.
`ifndef COMMENT_AND_WHITESPACE_STRIPPER_UNIT_ASSERT_SVH
`define COMMENT_AND_WHITESPACE_STRIPPER_UNIT_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define CWSU_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: label");

// Antecedent implies consequent in the same cycle.
`define CWSU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Antecedent implies consequent in the next cycle.
`define CWSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// File: sv/cwsu_pkg.sv
// Package for the comment and whitespace stripper: scan modes, character codes
// and the result records passed between the scanner and the result buffer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cwsu_pkg;

    // Character codes the scanner reacts to
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NUL       = 8'h00;

    typedef enum logic [7:0] {
        MODE_PLAIN = 8'b0000_0001,
        MODE_SLASH = 8'b0000_0010,
        MODE_BLOCK = 8'b0000_0100,
        MODE_STAR  = 8'b0000_1000,
        MODE_LINE  = 8'b0001_0000,
        MODE_BLANK = 8'b0010_0000,
        MODE_STR   = 8'b0100_0000,
        MODE_ESC   = 8'b1000_0000
    } scan_mode_t;

    // One result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       unterminated_comment;
        logic       last_of_run;
    } result_t;

    // All results caused by one input byte, in order (r0 first)
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } result_pair_t;

endpackage

`default_nettype wire

// File: sv/cwsu_scan.sv
// Scanner for the comment and whitespace stripper: holds the scan mode and the
// line comment enable, and decodes one byte into up to two results.
// Depends on cwsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwsu_scan
    import cwsu_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_write,
    input  wire logic         cfg_value,
    input  wire logic         step,
    input  wire logic [7:0]   cur_byte,
    input  wire logic         cur_last,
    output result_pair_t      pair
);

    scan_mode_t mode_reg;
    scan_mode_t mode_next;
    logic       lce_reg;

    logic       is_blank;
    logic       plain_emit;
    logic [7:0] plain_byte;
    scan_mode_t plain_mode;

    logic       pre_slash;
    logic       main_emit;
    logic [7:0] main_byte;
    scan_mode_t body_mode;
    logic       tail_emit;
    logic       tail_status;
    result_t    e_pre;
    result_t    e_main;
    result_t    e_tail;
    logic [1:0] count;

    assign is_blank = (cur_byte inside {CH_SPACE, CH_TAB});

    // Plain text handling, shared by several modes
    always_comb
    begin
        plain_emit = 1'b1;
        plain_byte = cur_byte;
        plain_mode = MODE_PLAIN;
        if (cur_byte == CH_SLASH)
        begin
            plain_emit = 1'b0;
            plain_mode = MODE_SLASH;
        end
        else if (is_blank)
        begin
            plain_byte = CH_SPACE;
            plain_mode = MODE_BLANK;
        end
        else if (cur_byte == CH_QUOTE)
        begin
            plain_mode = MODE_STR;
        end
    end

    always_comb
    begin
        pre_slash = 1'b0;
        main_emit = 1'b0;
        main_byte = cur_byte;
        body_mode = mode_reg;
        case (mode_reg)
            MODE_PLAIN:
            begin
                main_emit = plain_emit;
                main_byte = plain_byte;
                body_mode = plain_mode;
            end
            MODE_SLASH:
            begin
                if (cur_byte == CH_STAR)
                    body_mode = MODE_BLOCK;
                else if (cur_byte == CH_SLASH && lce_reg)
                    body_mode = MODE_LINE;
                else
                begin
                    pre_slash = 1'b1;
                    main_emit = plain_emit;
                    main_byte = plain_byte;
                    body_mode = plain_mode;
                end
            end
            MODE_BLOCK:
            begin
                if (cur_byte == CH_STAR)
                    body_mode = MODE_STAR;
            end
            MODE_STAR:
            begin
                if (cur_byte == CH_SLASH)
                    body_mode = MODE_PLAIN;
                else if (cur_byte != CH_STAR)
                    body_mode = MODE_BLOCK;
            end
            MODE_LINE:
            begin
                if (cur_byte == CH_NEWLINE)
                begin
                    main_emit = 1'b1;
                    body_mode = MODE_PLAIN;
                end
            end
            MODE_BLANK:
            begin
                if (!is_blank)
                begin
                    main_emit = plain_emit;
                    main_byte = plain_byte;
                    body_mode = plain_mode;
                end
            end
            MODE_STR:
            begin
                main_emit = 1'b1;
                if (cur_byte == CH_BACKSLASH)
                    body_mode = MODE_ESC;
                else if (cur_byte == CH_QUOTE)
                    body_mode = MODE_PLAIN;
            end
            MODE_ESC:
            begin
                main_emit = 1'b1;
                body_mode = MODE_STR;
            end
            default:
            begin
                body_mode = MODE_PLAIN;
            end
        endcase
    end

    // End of text: flush a held slash or flag an open block comment; back to plain
    always_comb
    begin
        tail_emit   = 1'b0;
        tail_status = 1'b0;
        mode_next   = body_mode;
        if (cur_last)
        begin
            if (body_mode == MODE_SLASH)
                tail_emit = 1'b1;
            else if (body_mode == MODE_BLOCK || body_mode == MODE_STAR)
                tail_status = 1'b1;
            mode_next = MODE_PLAIN;
        end
    end

    // Pack the emitted beats in order, last_of_run on the final one
    always_comb
    begin
        e_pre  = '{out_byte: CH_SLASH, byte_valid: 1'b1,
                   unterminated_comment: 1'b0, last_of_run: 1'b0};
        e_main = '{out_byte: main_byte, byte_valid: 1'b1,
                   unterminated_comment: 1'b0, last_of_run: 1'b0};
        e_tail = '{out_byte: tail_emit ? CH_SLASH : CH_NUL, byte_valid: tail_emit,
                   unterminated_comment: tail_status, last_of_run: 1'b0};
        count  = {1'b0, pre_slash} + {1'b0, main_emit}
               + {1'b0, tail_emit | tail_status};

        pair.count = count;
        pair.r0    = pre_slash ? e_pre : (main_emit ? e_main : e_tail);
        pair.r1    = (pre_slash && main_emit) ? e_main : e_tail;
        pair.r0.last_of_run = (count == 2'd1);
        pair.r1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            lce_reg  <= 1'b1;
        end
        else
        begin
            if (step)
                mode_reg <= mode_next;
            if (cfg_write)
                lce_reg <= cfg_value;
        end
    end

endmodule

`default_nettype wire

// File: sv/cwsu_result_buf.sv
// Result buffer for the comment and whitespace stripper: holds the one or two
// beats of a decoded byte and drains them one per cycle while out_ready is high.
// Depends on cwsu_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "comment_and_whitespace_stripper_unit_assert.svh"

module cwsu_result_buf
    import cwsu_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire result_pair_t pair,
    output logic              space,
    output logic              out_valid,
    input  wire logic         out_ready,
    output result_t           head
);

    logic [1:0] cnt_reg;
    result_t    r0_reg;
    result_t    r1_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    // Room for a new pair once the buffer empties by the end of this cycle
    assign space     = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign head      = r0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (load)
            cnt_reg <= pair.count;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r0_reg <= pair.r0;
            r1_reg <= pair.r1;
        end
        else if (pop)
        begin
            r0_reg <= r1_reg;
        end
    end

    `CWSU_ASSERT_ALWAYS(a_cnt_range, cnt_reg != 2'd3)
    `CWSU_ASSERT_SAME(a_load_has_room, load, space)
    `CWSU_ASSERT_SAME(a_single_is_last, cnt_reg == 2'd1, r0_reg.last_of_run)
    `CWSU_ASSERT_NEXT(a_pair_drains, cnt_reg == 2'd2 && out_ready && !load, cnt_reg == 2'd1)

endmodule

`default_nettype wire

// File: sv/comment_and_whitespace_stripper_unit.sv
// Comment and whitespace stripper, top level: input register, scanner and
// result buffer. Depends on cwsu_pkg, cwsu_scan and cwsu_result_buf.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one text byte per beat with
//   end_of_text set on the final byte of a text. Output channel
//   (out_valid/out_ready) carries one result beat: out_byte with byte_valid,
//   or a status-only beat with unterminated_comment set. last_of_run marks
//   the final beat caused by an input byte; a byte inside a comment or a
//   repeated blank causes no beat at all.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes line_comments_enable;
//   write it only while the block is idle. It is always ready.
// Timing:
//   An accepted byte waits in the input register, then the scanner decodes it
//   and loads its beats into the result buffer, which presents the first one.
//   Throughput is one byte per cycle while the result buffer has room; a byte
//   that releases a held slash and also emits itself (or a slash flushed at end
//   of text) produces two beats, which hold the next byte until one has drained.
// Reset:
//   Returns to plain text mode with line comments removed and both buffers
//   empty. A stalled receiver holds the result buffer, which then holds the
//   input register, which drops in_ready.
`timescale 1ns / 1ps
`default_nettype none

module comment_and_whitespace_stripper_unit
    import cwsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration write
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,
    // text byte in
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_text,
    // filtered result out
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            unterminated_comment,
    output logic            last_of_run
);

    logic         hold_valid_reg;
    logic [7:0]   hold_byte_reg;
    logic         hold_last_reg;
    logic         buf_space;
    logic         step;
    logic         in_fire;
    result_pair_t pair;
    result_t      head;

    assign cfg_ready = 1'b1;

    // Advance the held byte into the result buffer whenever it has room
    assign step     = hold_valid_reg && buf_space;
    assign in_ready = !hold_valid_reg || step;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (in_fire)
            hold_valid_reg <= 1'b1;
        else if (step)
            hold_valid_reg <= 1'b0;
    end

    // Payload holds without reset; only captured on an accepted beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hold_byte_reg <= in_byte;
            hold_last_reg <= end_of_text;
        end
    end

    cwsu_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid),
        .cfg_value (cfg_data),
        .step      (step),
        .cur_byte  (hold_byte_reg),
        .cur_last  (hold_last_reg),
        .pair      (pair)
    );

    cwsu_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .pair      (pair),
        .space     (buf_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_byte             = head.out_byte;
    assign byte_valid           = head.byte_valid;
    assign unterminated_comment = head.unterminated_comment;
    assign last_of_run          = head.last_of_run;

endmodule

`default_nettype wire
